[design/tmlmh_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlmh_pkg
// shared types, constants and helpers of the top-m largest min-heap block
// ----------------------------------------------------------------------------
package tmlmh_pkg;

	localparam int CAPACITY = 8;
	localparam int DATA_W   = 32;
	localparam int KEEP_W   = 4;
	localparam int SIZE_W   = 4;
	localparam int IDX_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int KEEP_RST = 5;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [ADDR_W-1:0]        addr_t;
	typedef logic [KEEP_W-1:0]        keep_t;
	typedef logic [SIZE_W-1:0]        size_t;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_REMOVE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		OC_APPENDED  = 2'd0,
		OC_REPLACED  = 2'd1,
		OC_DISCARDED = 2'd2,
		OC_EMPTY     = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROOT_RD,
		ST_ROOT_CHK,
		ST_UP_RD,
		ST_UP_CHK,
		ST_DN_RD,
		ST_DN_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic  we;
		addr_t addr;
		data_t data;
	} ram_wr_t;

	typedef struct packed {
		addr_t addr_a;
		addr_t addr_b;
	} ram_rd_t;

	// heap index (1-based) to memory address
	function automatic addr_t to_addr(idx_t i);
		idx_t t;
		t = i - idx_t'(1);
		return t[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

[design/tmlmh_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlmh_if
// request and result channels of the top-m largest min-heap block
// ----------------------------------------------------------------------------
interface tmlmh_in_if import tmlmh_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  operation;
	data_t value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

interface tmlmh_out_if import tmlmh_pkg::*; ();
	logic             valid;
	logic             ready;
	data_t            out_value;
	logic [1:0]       outcome;
	logic [SIZE_W-1:0] size_now;

	modport source (output valid, output out_value, output outcome, output size_now,
		input ready);
	modport sink   (input valid, input out_value, input outcome, input size_now,
		output ready);
endinterface
`default_nettype wire

[design/tmlmh_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlmh_ram
// generic memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tmlmh_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

[design/tmlmh_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tmlmh_ctrl
// sequencer and datapath: root check, sift-up and sift-down over the memory
// ----------------------------------------------------------------------------
module tmlmh_ctrl import tmlmh_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	tmlmh_in_if.sink    in_ch,
	tmlmh_out_if.source out_ch,
	input  wire idx_t   limit,
	output ram_wr_t     ram_wr,
	output ram_rd_t     ram_rd,
	input  wire data_t  rdata_a,
	input  wire data_t  rdata_b
);

	state_t   state_q, state_d;
	op_t      op_q;
	idx_t     size_q;
	idx_t     pos_q;
	idx_t     chd_q;
	data_t    x_q;
	data_t    res_q;
	outcome_t outc_q;

	logic     out_valid_q;
	data_t    out_val_q;
	outcome_t out_outc_q;
	idx_t     out_size_q;

	logic             accept;
	logic             out_free;
	idx_t             parent;
	logic [IDX_W:0]   child_w;
	idx_t             child_idx;
	logic             dn_leaf;
	logic             up_move;
	logic             use_right;
	data_t            sel_val;
	idx_t             sel_idx;
	logic             dn_move;
	logic             root_less;

	assign accept    = in_ch.valid && in_ch.ready;
	assign out_free  = !out_valid_q || out_ch.ready;
	assign parent    = pos_q >> 1;
	assign child_w   = {pos_q, 1'b0};
	assign child_idx = child_w[IDX_W-1:0];
	assign dn_leaf   = child_w > {1'b0, size_q};
	assign up_move   = x_q < rdata_a;
	assign use_right = (chd_q < size_q) && (rdata_b < rdata_a);
	assign sel_val   = use_right ? rdata_b : rdata_a;
	assign sel_idx   = use_right ? chd_q + idx_t'(1) : chd_q;
	assign dn_move   = sel_val < x_q;
	assign root_less = rdata_a < x_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_t'(in_ch.operation) == OP_INSERT) begin
						if (size_q < limit) begin
							state_d = ST_UP_RD;
						end else if (size_q != '0) begin
							state_d = ST_ROOT_RD;
						end else begin
							state_d = ST_DONE;
						end
					end else if (size_q != '0) begin
						state_d = ST_ROOT_RD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_ROOT_RD: state_d = ST_ROOT_CHK;
			ST_ROOT_CHK: begin
				if (op_q == OP_REMOVE || root_less) begin
					state_d = ST_DN_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_UP_RD: state_d = (pos_q == idx_t'(1)) ? ST_DONE : ST_UP_CHK;
			ST_UP_CHK: state_d = up_move ? ST_UP_RD : ST_DONE;
			ST_DN_RD: state_d = dn_leaf ? ST_DONE : ST_DN_CHK;
			ST_DN_CHK: state_d = dn_move ? ST_DN_RD : ST_DONE;
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// memory ports and request handshake
	always_comb begin
		in_ch.ready   = (state_q == ST_IDLE);
		ram_wr        = '0;
		ram_rd.addr_a = '0;
		ram_rd.addr_b = '0;
		case (state_q)
			ST_ROOT_RD: begin
				ram_rd.addr_a = to_addr(idx_t'(1));
				ram_rd.addr_b = to_addr(size_q);
			end
			ST_UP_RD: begin
				if (pos_q == idx_t'(1)) begin
					ram_wr.we   = 1'b1;
					ram_wr.addr = to_addr(pos_q);
					ram_wr.data = x_q;
				end else begin
					ram_rd.addr_a = to_addr(parent);
				end
			end
			ST_UP_CHK: begin
				ram_wr.we   = 1'b1;
				ram_wr.addr = to_addr(pos_q);
				ram_wr.data = up_move ? rdata_a : x_q;
			end
			ST_DN_RD: begin
				if (dn_leaf) begin
					ram_wr.we   = (pos_q <= size_q);
					ram_wr.addr = to_addr(pos_q);
					ram_wr.data = x_q;
				end else begin
					ram_rd.addr_a = to_addr(child_idx);
					ram_rd.addr_b = (child_idx < size_q) ? to_addr(child_idx + idx_t'(1))
						: to_addr(child_idx);
				end
			end
			ST_DN_CHK: begin
				ram_wr.we   = 1'b1;
				ram_wr.addr = to_addr(pos_q);
				ram_wr.data = dn_move ? sel_val : x_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && accept && op_t'(in_ch.operation) == OP_INSERT
				&& size_q < limit) begin
				size_q <= size_q + idx_t'(1);
			end else if (state_q == ST_ROOT_CHK && op_q == OP_REMOVE) begin
				size_q <= size_q - idx_t'(1);
			end
		end
	end

	// item payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q  <= op_t'(in_ch.operation);
					x_q   <= in_ch.value;
					res_q <= '0;
					pos_q <= size_q + idx_t'(1);
					if (op_t'(in_ch.operation) == OP_INSERT) begin
						outc_q <= (size_q < limit) ? OC_APPENDED : OC_DISCARDED;
					end else begin
						outc_q <= OC_EMPTY;
					end
				end
			end
			ST_ROOT_CHK: begin
				pos_q <= idx_t'(1);
				if (op_q == OP_REMOVE) begin
					res_q  <= rdata_a;
					x_q    <= rdata_b;
					outc_q <= OC_APPENDED;
				end else begin
					outc_q <= root_less ? OC_REPLACED : OC_DISCARDED;
				end
			end
			ST_UP_CHK: begin
				if (up_move) begin
					pos_q <= parent;
				end
			end
			ST_DN_RD: begin
				chd_q <= child_idx;
			end
			ST_DN_CHK: begin
				if (dn_move) begin
					pos_q <= sel_idx;
				end
			end
			default: begin
			end
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_val_q  <= res_q;
			out_outc_q <= outc_q;
			out_size_q <= size_q;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_value = out_val_q;
	assign out_ch.outcome   = out_outc_q;
	assign out_ch.size_now  = SIZE_W'(out_size_q);

	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		size_q <= idx_t'(CAPACITY))
		else $error("heap count above capacity");

	a_write_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr.we |-> (pos_q != '0) && (pos_q <= size_q))
		else $error("memory write outside the held entries");

	a_size_step: assert property (@(posedge clk) disable iff (!arst_n)
		(size_q != $past(size_q)) |->
			($past(state_q) == ST_IDLE || $past(state_q) == ST_ROOT_CHK))
		else $error("heap count changed outside an update point");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside completion");

endmodule
`default_nettype wire

[design/top_m_largest_min_heap_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// top_m_largest_min_heap_top
// keeps the largest signed values of a stream in a binary min-heap
// ----------------------------------------------------------------------------
// a request walks the heap level by level; the number of levels passed is at most
//   log2 of capacity, and each level costs a memory read and a compare/write state
// one request at a time: a new one is taken only once the last has finished and its
//   result has gone into the output register, which waits while an older result is held
// reset: heap empty, keep_count 5, memory contents left as they are
module top_m_largest_min_heap_top import tmlmh_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tmlmh_in_if.sink               in_ch,
	tmlmh_out_if.source            out_ch,
	input  wire logic              cfg_we,
	input  wire logic [KEEP_W-1:0] cfg_wdata
);

	keep_t   keep_q;
	idx_t    limit;
	ram_wr_t ram_wr;
	ram_rd_t ram_rd;
	data_t   rdata_a;
	data_t   rdata_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= keep_t'(KEEP_RST);
		end else if (cfg_we) begin
			keep_q <= cfg_wdata;
		end
	end

	assign limit = (int'(keep_q) > CAPACITY) ? idx_t'(CAPACITY) : idx_t'(keep_q);

	tmlmh_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.limit   (limit),
		.ram_wr  (ram_wr),
		.ram_rd  (ram_rd),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	tmlmh_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (DATA_W)
	) u_ram (
		.clk     (clk),
		.we      (ram_wr.we),
		.waddr   (ram_wr.addr),
		.wdata   (ram_wr.data),
		.raddr_a (ram_rd.addr_a),
		.raddr_b (ram_rd.addr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

endmodule
`default_nettype wire
